// File: rtl/core/fir_filter_circular_delay_line_assert.svh
// ----------------------------------------------------------------------------
// FIR filter assertion macros
// Shared wrappers for the concurrent checks of the FIR filter block.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_CIRCULAR_DELAY_LINE_ASSERT_SVH
`define FIR_FILTER_CIRCULAR_DELAY_LINE_ASSERT_SVH

// property holds in the same cycle as its trigger
`define FIRCDL_ASSERT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// property holds in the cycle after its trigger
`define FIRCDL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/fircdl_pkg.sv
// ----------------------------------------------------------------------------
// FIR filter package
// Widths, reset values and control types shared by the FIR filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fircdl_pkg;

  localparam int SMP_W     = 16;
  localparam int PROD_W    = 2 * SMP_W;
  localparam int ACC_W     = PROD_W + 4;
  localparam int FRAC_W    = 15;
  localparam int NUM_COEFS = 8;
  localparam int COEF_IW   = 3;
  localparam int CFG_IW    = 4;
  localparam int TAPS_DEF  = 5;
  localparam int RST_TAPS  = 5;

  localparam logic signed [SMP_W-1:0] COEF_RST = 16'sd3277;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_ACC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic rot;
  } cell_ctrl_t;

  typedef struct packed {
    logic clr;
    logic mul;
  } mac_ctrl_t;

  function automatic logic signed [SMP_W-1:0] coef_rst(input int idx);
    return (idx < RST_TAPS) ? COEF_RST : '0;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fircdl_cell.sv
// ----------------------------------------------------------------------------
// FIR delay cell
// One sample of the delay line; shifts older on insert, toward the head on rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module fircdl_cell import fircdl_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cell_ctrl_t              ctrl,
  input  wire logic signed [SMP_W-1:0] d_prev,
  input  wire logic signed [SMP_W-1:0] d_next,
  output logic signed [SMP_W-1:0]      q
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      q <= '0;
    end else if (ctrl.ins) begin
      q <= d_prev;
    end else if (ctrl.rot) begin
      q <= d_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fircdl_mac.sv
// ----------------------------------------------------------------------------
// FIR multiply-accumulate
// Registered product, wide accumulator, round-half-up and 16-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module fircdl_mac import fircdl_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire mac_ctrl_t               ctrl,
  input  wire logic signed [SMP_W-1:0] a,
  input  wire logic signed [SMP_W-1:0] b,
  output logic signed [SMP_W-1:0]      y
);

  localparam int SUM_W = ACC_W + 1;
  localparam int SH_W  = SUM_W - FRAC_W;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.mul;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign sum     = SUM_W'(acc) + SUM_W'(1 << (FRAC_W - 1));
  assign shifted = sum[SUM_W-1:FRAC_W];

  always_comb begin
    if (&shifted[SH_W-1:SMP_W-1] || ~|shifted[SH_W-1:SMP_W-1]) begin
      y = shifted[SMP_W-1:0];
    end else if (shifted[SH_W-1]) begin
      y = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fir_filter_circular_delay_line.sv
// ----------------------------------------------------------------------------
// FIR filter, direct form
// Q1.15 FIR over a row of delay cells with one shared multiply-accumulate.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------
//   in       | in_valid / in_stall  | flush, sample_in
//   out      | out_valid / out_stall| sample_out
//   cfg      | cfg_we               | cfg_index, cfg_data
//
// After a sample transfer the block steps through S_MAC, where the shared
// multiplier works while the cells rotate past it, S_ACC to accumulate and
// S_OUT to load the output. A new item transfers only in S_IDLE, after that load.
// A flush clears the cells and gives no result.
// Reset clears the cells and loads the coefficient reset values.
// A stalled result holds the next one in the block, and the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_circular_delay_line import fircdl_pkg::*; #(
  parameter int TAPS = TAPS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    flush,
  input  wire logic signed [SMP_W-1:0] sample_in,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [SMP_W-1:0]      sample_out,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IW-1:0]       cfg_index,
  input  wire logic signed [SMP_W-1:0] cfg_data
);

  localparam int KW = (TAPS > 1) ? $clog2(TAPS) : 1;

  state_t                   state, state_next;
  logic [KW-1:0]            k, k_next;
  logic signed [SMP_W-1:0]  coef [NUM_COEFS];
  logic signed [SMP_W-1:0]  tap  [TAPS];
  cell_ctrl_t               cc;
  mac_ctrl_t                mc;
  logic signed [SMP_W-1:0]  mac_y;
  logic                     out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef[i] <= coef_rst(i);
      end
    end else if (cfg_we && cfg_index < CFG_IW'(NUM_COEFS)) begin
      coef[cfg_index[COEF_IW-1:0]] <= cfg_data;
    end
  end

  for (genvar g = 0; g < TAPS; g++) begin : g_cell
    logic signed [SMP_W-1:0] d_prev, d_next;
    if (g == 0) begin : g_head
      assign d_prev = sample_in;
    end else begin : g_body
      assign d_prev = tap[g-1];
    end
    if (g == TAPS - 1) begin : g_tail
      assign d_next = tap[0];
    end else begin : g_mid
      assign d_next = tap[g+1];
    end
    fircdl_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (cc),
      .d_prev (d_prev),
      .d_next (d_next),
      .q      (tap[g])
    );
  end

  fircdl_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mc),
    .a    (tap[0]),
    .b    (coef[COEF_IW'(k)]),
    .y    (mac_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    cc         = '0;
    mc         = '0;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        k_next   = '0;
        if (in_valid) begin
          if (flush) begin
            cc.clr = 1'b1;
          end else begin
            cc.ins     = 1'b1;
            mc.clr     = 1'b1;
            state_next = S_MAC;
          end
        end
      end
      S_MAC: begin
        mc.mul = 1'b1;
        cc.rot = 1'b1;
        if (k == KW'(TAPS - 1)) begin
          state_next = S_ACC;
        end else begin
          k_next = k + 1'b1;
        end
      end
      S_ACC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= mac_y;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fircdl_chk.sv
// ----------------------------------------------------------------------------
// FIR filter port checker
// Port-level checks of the FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fir_filter_circular_delay_line_assert.svh"

module fircdl_chk import fircdl_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    flush,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [SMP_W-1:0] sample_out
);

  logic in_xfer;

  assign in_xfer = in_valid && !in_stall;

  `FIRCDL_ASSERT_NEXT(a_sample_busy, clk, rst, in_xfer && !flush, in_stall, "sample transfer did not stall input")
  `FIRCDL_ASSERT_NEXT(a_flush_idle, clk, rst, in_xfer && flush, !in_stall, "flush left input stalled")
  `FIRCDL_ASSERT(a_result_after_work, clk, rst, $rose(out_valid), $past(in_stall), "result appeared while idle")
  `FIRCDL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(sample_out), "stalled result changed")

endmodule

bind fir_filter_circular_delay_line fircdl_chk u_fircdl_chk (.*);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FIR filter testbench
// Drives samples and flushes through the valid/stall input channel, programs
// the coefficient registers between phases and checks every filtered output
// against a cycle-free Q1.15 model of the circular delay line kept in the
// bench. Traffic runs with and without idle cycles and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import fircdl_pkg::*;

  localparam int TAPS         = TAPS_DEF;
  localparam int DRAIN_CYCLES = 2 * (TAPS + 3) + 4;
  localparam int MAX_GAP      = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;

  localparam logic [CFG_IW-1:0] REG_COEF_FIRST = '0;
  localparam logic [CFG_IW-1:0] REG_COEF_LAST  = CFG_IW'(NUM_COEFS - 1);
  localparam logic [CFG_IW-1:0] REG_SPARE_LO   = CFG_IW'(NUM_COEFS);
  localparam logic [CFG_IW-1:0] REG_SPARE_HI   = '1;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;
  localparam logic signed [SMP_W-1:0] Q_HALF  = 16'sd16384;

  typedef enum int {CM_RANDOM, CM_MAX, CM_MIN, CM_SMALL, CM_ALTERNATE} coef_mode_t;

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic                    flush     = 1'b0;
  logic signed [SMP_W-1:0] sample_in = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SMP_W-1:0] sample_out;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IW-1:0]       cfg_index = '0;
  logic signed [SMP_W-1:0] cfg_data  = '0;

  fir_filter_circular_delay_line #(.TAPS(TAPS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .flush     (flush),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic signed [SMP_W-1:0] coef_copy [NUM_COEFS];
  logic signed [SMP_W-1:0] tap_hist [TAPS];
  int                      wr_pos;
  logic signed [SMP_W-1:0] pending_out [$];
  logic signed [SMP_W-1:0] exp_out;
  int                      err_count     = 0;
  int                      send_idle_pct = 0;
  int                      stall_pct     = 0;
  int                      hold_req      = 0;
  int                      hold_seen     = 0;
  int                      hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("fir_filter_circular_delay_line verification failed");
    $finish;
  end

  function automatic void fir_clear();
    for (int i = 0; i < TAPS; i++) tap_hist[i] = '0;
    wr_pos = 0;
  endfunction

  function automatic logic signed [SMP_W-1:0] fir_predict(input logic signed [SMP_W-1:0] s);
    longint acc;
    longint y;
    int     rd;
    tap_hist[wr_pos] = s;
    rd  = wr_pos;
    acc = 0;
    for (int k = 0; k < TAPS && k < NUM_COEFS; k++) begin
      acc += longint'(tap_hist[rd]) * longint'(coef_copy[k]);
      rd = (rd == 0) ? TAPS - 1 : rd - 1;
    end
    y = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    if (y > longint'(SMP_MAX)) y = longint'(SMP_MAX);
    if (y < longint'(SMP_MIN)) y = longint'(SMP_MIN);
    wr_pos = (wr_pos == TAPS - 1) ? 0 : wr_pos + 1;
    return y[SMP_W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [SMP_W-1:0] want,
                               input logic [SMP_W-1:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s: expected %0d got %0d", $realtime, what, $signed(want), $signed(got));
  endtask

  // hold-off counter for long receiver stalls
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= (hold_req != hold_seen) || (hold_left > 1) ||
                 ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        note_mismatch("unexpected sample_out", 'x, sample_out);
      end else begin
        exp_out = pending_out.pop_front();
        if (sample_out !== exp_out) note_mismatch("sample_out", exp_out, sample_out);
      end
    end
  end

  task automatic send_item(input logic is_flush, input logic signed [SMP_W-1:0] smp);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    flush     <= is_flush;
    sample_in <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (is_flush) fir_clear();
    else pending_out.push_back(fir_predict(smp));
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results();
    end_burst();
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic signed [SMP_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx <= REG_COEF_LAST) coef_copy[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_coefs(input coef_mode_t mode);
    logic signed [SMP_W-1:0] v;
    drain();
    for (int i = REG_COEF_FIRST; i <= REG_COEF_LAST; i++) begin
      case (mode)
        CM_MAX:       v = SMP_MAX;
        CM_MIN:       v = SMP_MIN;
        CM_SMALL:     v = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
        CM_ALTERNATE: v = i[0] ? SMP_MAX : SMP_MIN;
        default:      v = SMP_W'($urandom);
      endcase
      write_reg(i[CFG_IW-1:0], v);
    end
  endtask

  function automatic logic signed [SMP_W-1:0] random_sample();
    case ($urandom_range(0, 15))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return $signed(16'($urandom_range(0, 255))) - 16'sd128;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_coefs();
    repeat (TAPS) send_item(1'b0, SMP_MAX);
    send_item(1'b0, SMP_MIN);
    send_item(1'b1, SMP_W'($urandom));
    send_item(1'b0, 16'sd100);
    drain();
  endtask

  task automatic test_saturation();
    for (int i = REG_COEF_FIRST; i <= REG_COEF_LAST; i++) write_reg(i[CFG_IW-1:0], SMP_MIN);
    write_reg(REG_SPARE_LO, SMP_MAX);
    write_reg(REG_SPARE_HI, SMP_MAX);
    repeat (TAPS) send_item(1'b0, SMP_MIN);
    repeat (3) send_item(1'b0, SMP_MAX);
    drain();
  endtask

  // half-LSB ties round up; coefficients past the tap count have no effect
  task automatic test_rounding_unused();
    for (int i = REG_COEF_FIRST; i <= REG_COEF_LAST; i++)
      write_reg(i[CFG_IW-1:0], (i == REG_COEF_FIRST) ? Q_HALF :
                               (i >= TAPS) ? SMP_MAX : '0);
    send_item(1'b1, SMP_MAX);
    send_item(1'b0, 16'sd1);
    send_item(1'b0, -16'sd1);
    send_item(1'b0, 16'sd3);
    drain();
  endtask

  task automatic test_random_traffic(input int n, input coef_mode_t mode,
                                     input int s_pct, input int r_pct);
    load_coefs(mode);
    send_idle_pct = s_pct;
    stall_pct     = r_pct;
    repeat (n) send_item($urandom_range(0, 24) == 0, random_sample());
    drain();
  endtask

  task automatic test_backpressure();
    load_coefs(CM_RANDOM);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = hold_req + 1;
    repeat (16) send_item($urandom_range(0, 15) == 0, random_sample());
    drain();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 0;
    stall_pct     = 29;
    repeat (10) send_item(1'b0, random_sample());
    wait_results();
    repeat (10) send_item($urandom_range(0, 9) == 0, random_sample());
    drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_COEFS; i++) coef_copy[i] = (i < RST_TAPS) ? COEF_RST : '0;
    fir_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_coefs();
    test_saturation();
    test_rounding_unused();
    test_random_traffic(320, CM_RANDOM,    0,  0);
    test_random_traffic(320, CM_MAX,       79, 0);
    test_random_traffic(320, CM_SMALL,     0,  79);
    test_random_traffic(320, CM_ALTERNATE, 29, 29);
    test_backpressure();
    test_drain_pause();
    stall_pct = 0;
    drain();

    if (err_count == 0 && pending_out.size() == 0) begin
      $display("fir_filter_circular_delay_line verification clean");
    end else begin
      $display("fir_filter_circular_delay_line verification failed");
    end
    $finish;
  end

endmodule
